/* sv/uscd_pkg.sv */
package uscd_pkg;

   // field widths
   localparam int SECS_W   = 64;
   localparam int YEAR_W   = 16;
   localparam int MONTH_W  = 4;
   localparam int DOM_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int WDAY_W   = 3;

   // seconds -> days: 86400 = 675 << 7, long division by 675 in 16-bit digits
   localparam int DAY_SHIFT    = 7;
   localparam int DAY_DIVISOR  = 675;
   localparam int DAY_CHUNK_W  = 16;
   localparam int DAY_REM_W    = 10;
   localparam int DAY_X_W      = DAY_REM_W + DAY_CHUNK_W;
   localparam int DAYS_W       = 3 * DAY_CHUNK_W;
   localparam int TOD_W        = DAY_REM_W + DAY_SHIFT;

   // days -> era / day of era, long division by 146097 in 14-bit digits
   localparam int EPOCH_SHIFT  = 719468;
   localparam int DAYS_PER_ERA = 146097;
   localparam int Z_W          = DAYS_W + 1;
   localparam int ERA_CHUNK_W  = 14;
   localparam int ERA_REM_W    = 18;
   localparam int ERA_X_W      = ERA_REM_W + ERA_CHUNK_W;
   localparam int ZLO_W        = 2 * ERA_CHUNK_W;
   localparam int ZHI_W        = Z_W - ZLO_W;
   localparam int ERA_LO_W     = YEAR_W;
   localparam int DOE_W        = ERA_REM_W;

   localparam int DAYS_PER_4Y      = 1460;
   localparam int DAYS_PER_CENTURY = 36524;
   localparam int DAYS_PER_YEAR    = 365;
   localparam int YEARS_PER_ERA    = 400;
   localparam int YOE_W            = 9;
   localparam int DOY_W            = 9;
   localparam int MP_DIVISOR       = 153;
   localparam int MP_NUM_W         = 11;
   localparam int MP_W             = 4;
   localparam int MP_JANUARY       = 10;
   localparam int MP_REM_W         = 8;
   localparam int DOM_DIVISOR      = 5;

   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;
   localparam int HOUR_REM_W    = 12;
   localparam int DAYS_PER_WEEK = 7;
   // 1970-01-01 was a Thursday and eras are whole weeks: weekday = (doe + 3) mod 7
   localparam int WEEKDAY_BIAS  = 3;

   // pipeline depth
   localparam int DAYS_STAGES  = 6;
   localparam int CIVIL_STAGES = 19;
   localparam int NUM_STAGES   = DAYS_STAGES + CIVIL_STAGES;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DOM_W-1:0]    day_of_month;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic [WDAY_W-1:0]   weekday;
   } result_type;

endpackage

/* sv/uscd_cdiv.sv */
// Two-stage divide by a constant: reciprocal estimate, then one correction step.
// The estimate is floor(x * floor(2^XW / DIVISOR) / 2^XW), low by at most one.
module uscd_cdiv #(
   parameter int XW      = 26,
   parameter int QW      = 16,
   parameter int RW      = 10,
   parameter int DIVISOR = 675
) (
   input  logic          clock,
   input  logic [1:0]    en_i,
   input  logic [XW-1:0] x_i,
   output logic [QW-1:0] quo_o,
   output logic [RW-1:0] rem_o
);

   localparam longint unsigned RECIP = (64'd1 << XW) / DIVISOR;
   localparam int MW = $clog2(RECIP + 1);
   localparam logic [MW-1:0] RECIP_V = MW'(RECIP);
   localparam logic [XW:0]   DIV_X   = (XW + 1)'(DIVISOR);
   localparam logic [RW:0]   DIV_R   = (RW + 1)'(DIVISOR);

   logic [XW+MW-1:0] prod;
   logic [QW-1:0]    qest_in, qest_ff;
   logic [XW-1:0]    x_ff;
   logic [XW:0]      back;
   logic [RW:0]      rest;
   logic [QW-1:0]    quo_in, quo_ff;
   logic [RW-1:0]    rem_in, rem_ff;

   always_comb begin
      prod    = (XW + MW)'(x_i) * (XW + MW)'(RECIP_V);
      qest_in = QW'(prod >> XW);
   end

   always_comb begin
      back = (XW + 1)'(x_ff) - (XW + 1)'(qest_ff) * DIV_X;
      rest = back[RW:0];
      if (rest >= DIV_R) begin
         quo_in = qest_ff + QW'(1);
         rem_in = RW'(rest - DIV_R);
      end else begin
         quo_in = qest_ff;
         rem_in = rest[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_i[0]) begin
         qest_ff <= qest_in;
         x_ff    <= x_i;
      end
      if (en_i[1]) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quo_o = quo_ff;
   assign rem_o = rem_ff;

endmodule

/* sv/uscd_days.sv */
// Seconds -> whole days and seconds of day.
// secs >> 7 is divided by 675 one 16-bit digit at a time; the top 25 bits go in first.
module uscd_days
   import uscd_pkg::*;
(
   input  logic                   clock,
   input  logic [DAYS_STAGES-1:0] en_i,
   input  logic [SECS_W-1:0]      secs_i,
   output logic [DAYS_W-1:0]      days_o,
   output logic [TOD_W-1:0]       tod_o
);

   localparam int LO_W = DAY_SHIFT + 2 * DAY_CHUNK_W;

   typedef struct packed {
      logic [LO_W-1:0]        lo;
      logic [DAY_CHUNK_W-1:0] q2;
      logic [DAY_CHUNK_W-1:0] q1;
   } days_side_type;

   days_side_type side_in [DAYS_STAGES];
   days_side_type side_ff [DAYS_STAGES];

   logic [DAY_CHUNK_W-1:0] k2_q, k1_q, k0_q;
   logic [DAY_REM_W-1:0]   k2_r, k1_r, k0_r;

   always_comb begin
      side_in[0]    = '0;
      side_in[0].lo = secs_i[LO_W-1:0];
      for (int i = 1; i < DAYS_STAGES; i++) begin
         side_in[i] = side_ff[i-1];
      end
      side_in[2].q2 = k2_q;
      side_in[4].q1 = k1_q;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DAYS_STAGES; i++) begin
         if (en_i[i]) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   uscd_cdiv #(.XW(DAY_X_W), .QW(DAY_CHUNK_W), .RW(DAY_REM_W), .DIVISOR(DAY_DIVISOR)) u_k2 (
      .clock (clock),
      .en_i  (en_i[1:0]),
      .x_i   (DAY_X_W'(secs_i[SECS_W-1:LO_W])),
      .quo_o (k2_q),
      .rem_o (k2_r)
   );

   uscd_cdiv #(.XW(DAY_X_W), .QW(DAY_CHUNK_W), .RW(DAY_REM_W), .DIVISOR(DAY_DIVISOR)) u_k1 (
      .clock (clock),
      .en_i  (en_i[3:2]),
      .x_i   ({k2_r, side_ff[1].lo[LO_W-1:DAY_SHIFT+DAY_CHUNK_W]}),
      .quo_o (k1_q),
      .rem_o (k1_r)
   );

   uscd_cdiv #(.XW(DAY_X_W), .QW(DAY_CHUNK_W), .RW(DAY_REM_W), .DIVISOR(DAY_DIVISOR)) u_k0 (
      .clock (clock),
      .en_i  (en_i[5:4]),
      .x_i   ({k1_r, side_ff[3].lo[DAY_SHIFT+DAY_CHUNK_W-1:DAY_SHIFT]}),
      .quo_o (k0_q),
      .rem_o (k0_r)
   );

   assign days_o = {side_ff[5].q2, side_ff[5].q1, k0_q};
   assign tod_o  = {k0_r, side_ff[5].lo[DAY_SHIFT-1:0]};

endmodule

/* sv/uscd_civil.sv */
// Days since epoch -> civil date, plus time of day split and weekday.
module uscd_civil
   import uscd_pkg::*;
(
   input  logic                    clock,
   input  logic [CIVIL_STAGES-1:0] en_i,
   input  logic [DAYS_W-1:0]       days_i,
   input  logic [TOD_W-1:0]        tod_i,
   output result_type              rsp_o
);

   localparam int SIDE_N = CIVIL_STAGES - 1;

   typedef struct packed {
      logic [ZHI_W-1:0]                   zhi;
      logic [ZLO_W-1:0]                   zlo;
      logic [TOD_W-1:0]                   tod;
      logic [ERA_LO_W-ERA_CHUNK_W-1:0]    era_q1;
      logic [ERA_CHUNK_W-1:0]             era_q0;
      logic [HOUR_W-1:0]                  hour;
      logic [MINUTE_W-1:0]                minute;
      logic [SECOND_W-1:0]                second;
      logic [DOE_W-1:0]                   doe;
      logic [2:0]                         cent;
      logic                               last_day;
      logic [DOE_W-1:0]                   yoe_num;
      logic [WDAY_W-1:0]                  weekday;
      logic [DOY_W-1:0]                   doy;
      logic [YEAR_W-1:0]                  ybase;
      logic [MP_NUM_W-1:0]                mp_num;
      logic [MP_W-1:0]                    mp;
   } civil_side_type;

   civil_side_type side_in [SIDE_N];
   civil_side_type side_ff [SIDE_N];
   result_type     rsp_in, rsp_ff;

   logic [Z_W-1:0]         z;
   logic [ERA_CHUNK_W-1:0] era1_q, era0_q;
   logic [ERA_REM_W-1:0]   era2_r, era1_r, era0_r;
   logic [HOUR_W-1:0]      hour_q;
   logic [HOUR_REM_W-1:0]  hour_r;
   logic [MINUTE_W-1:0]    min_q;
   logic [SECOND_W-1:0]    min_r;
   logic [6:0]             q4y;
   logic [WDAY_W-1:0]      wd_r;
   logic [YOE_W-1:0]       yoe_q;
   logic [MP_W-1:0]        mp_q;
   logic [MP_REM_W-1:0]    mp_r;
   logic [DOM_W-1:0]       dom_q;
   logic [2:0]             cent_doe;
   logic [1:0]             cent_yoe;
   logic [DOE_W-1:0]       yoe_days;

   // centuries within the era, doe / 36524 (0..4)
   always_comb begin
      if (era0_r >= DOE_W'(4 * DAYS_PER_CENTURY)) begin
         cent_doe = 3'd4;
      end else if (era0_r >= DOE_W'(3 * DAYS_PER_CENTURY)) begin
         cent_doe = 3'd3;
      end else if (era0_r >= DOE_W'(2 * DAYS_PER_CENTURY)) begin
         cent_doe = 3'd2;
      end else if (era0_r >= DOE_W'(DAYS_PER_CENTURY)) begin
         cent_doe = 3'd1;
      end else begin
         cent_doe = 3'd0;
      end
   end

   // yoe / 100 (0..3)
   always_comb begin
      if (yoe_q >= YOE_W'(300)) begin
         cent_yoe = 2'd3;
      end else if (yoe_q >= YOE_W'(200)) begin
         cent_yoe = 2'd2;
      end else if (yoe_q >= YOE_W'(100)) begin
         cent_yoe = 2'd1;
      end else begin
         cent_yoe = 2'd0;
      end
   end

   always_comb begin
      z        = Z_W'(days_i) + Z_W'(EPOCH_SHIFT);
      yoe_days = DOE_W'(yoe_q) * DOE_W'(DAYS_PER_YEAR) + DOE_W'(yoe_q >> 2)
                 - DOE_W'(cent_yoe);

      side_in[0]     = '0;
      side_in[0].zhi = z[Z_W-1:ZLO_W];
      side_in[0].zlo = z[ZLO_W-1:0];
      side_in[0].tod = tod_i;
      for (int i = 1; i < SIDE_N; i++) begin
         side_in[i] = side_ff[i-1];
      end

      side_in[3].hour = hour_q;

      side_in[5].minute = min_q;
      side_in[5].second = min_r;
      side_in[5].era_q1 = era1_q[ERA_LO_W-ERA_CHUNK_W-1:0];

      side_in[7].doe      = era0_r;
      side_in[7].era_q0   = era0_q;
      side_in[7].cent     = cent_doe;
      side_in[7].last_day = (era0_r == DOE_W'(4 * DAYS_PER_CENTURY));

      side_in[9].yoe_num = side_ff[8].doe - DOE_W'(q4y) + DOE_W'(side_ff[8].cent)
                           - DOE_W'(side_ff[8].last_day);
      side_in[9].weekday = wd_r;

      side_in[12].doy   = DOY_W'(side_ff[11].doe - yoe_days);
      side_in[12].ybase = {side_ff[11].era_q1, side_ff[11].era_q0} * YEAR_W'(YEARS_PER_ERA)
                          + YEAR_W'(yoe_q);

      side_in[13].mp_num = MP_NUM_W'(side_ff[12].doy) * MP_NUM_W'(5) + MP_NUM_W'(2);

      side_in[16].mp = mp_q;
   end

   // month counted from March: January and February belong to the next year
   always_comb begin
      rsp_in.year = side_ff[17].ybase + YEAR_W'(side_ff[17].mp >= MP_W'(MP_JANUARY));
      if (side_ff[17].mp < MP_W'(MP_JANUARY)) begin
         rsp_in.month = side_ff[17].mp + MONTH_W'(3);
      end else begin
         rsp_in.month = side_ff[17].mp - MONTH_W'(MP_JANUARY - 1);
      end
      rsp_in.day_of_month = dom_q + DOM_W'(1);
      rsp_in.hour         = side_ff[17].hour;
      rsp_in.minute       = side_ff[17].minute;
      rsp_in.second       = side_ff[17].second;
      rsp_in.weekday      = side_ff[17].weekday;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SIDE_N; i++) begin
         if (en_i[i]) begin
            side_ff[i] <= side_in[i];
         end
      end
      if (en_i[CIVIL_STAGES-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_o = rsp_ff;

   // era digits: only the remainders and the low quotient bits are needed
   uscd_cdiv #(.XW(ERA_X_W), .QW(ERA_CHUNK_W), .RW(ERA_REM_W), .DIVISOR(DAYS_PER_ERA)) u_era2 (
      .clock (clock),
      .en_i  (en_i[2:1]),
      .x_i   (ERA_X_W'(side_ff[0].zhi)),
      .quo_o (),
      .rem_o (era2_r)
   );

   uscd_cdiv #(.XW(ERA_X_W), .QW(ERA_CHUNK_W), .RW(ERA_REM_W), .DIVISOR(DAYS_PER_ERA)) u_era1 (
      .clock (clock),
      .en_i  (en_i[4:3]),
      .x_i   ({era2_r, side_ff[2].zlo[ZLO_W-1:ERA_CHUNK_W]}),
      .quo_o (era1_q),
      .rem_o (era1_r)
   );

   uscd_cdiv #(.XW(ERA_X_W), .QW(ERA_CHUNK_W), .RW(ERA_REM_W), .DIVISOR(DAYS_PER_ERA)) u_era0 (
      .clock (clock),
      .en_i  (en_i[6:5]),
      .x_i   ({era1_r, side_ff[4].zlo[ERA_CHUNK_W-1:0]}),
      .quo_o (era0_q),
      .rem_o (era0_r)
   );

   uscd_cdiv #(.XW(TOD_W), .QW(HOUR_W), .RW(HOUR_REM_W), .DIVISOR(SECS_PER_HOUR)) u_hour (
      .clock (clock),
      .en_i  (en_i[2:1]),
      .x_i   (side_ff[0].tod),
      .quo_o (hour_q),
      .rem_o (hour_r)
   );

   uscd_cdiv #(.XW(HOUR_REM_W), .QW(MINUTE_W), .RW(SECOND_W), .DIVISOR(SECS_PER_MIN)) u_min (
      .clock (clock),
      .en_i  (en_i[4:3]),
      .x_i   (hour_r),
      .quo_o (min_q),
      .rem_o (min_r)
   );

   uscd_cdiv #(.XW(DOE_W), .QW(7), .RW(11), .DIVISOR(DAYS_PER_4Y)) u_q4y (
      .clock (clock),
      .en_i  (en_i[8:7]),
      .x_i   (era0_r),
      .quo_o (q4y),
      .rem_o ()
   );

   uscd_cdiv #(.XW(DOE_W), .QW(15), .RW(WDAY_W), .DIVISOR(DAYS_PER_WEEK)) u_wday (
      .clock (clock),
      .en_i  (en_i[8:7]),
      .x_i   (era0_r + DOE_W'(WEEKDAY_BIAS)),
      .quo_o (),
      .rem_o (wd_r)
   );

   uscd_cdiv #(.XW(DOE_W), .QW(YOE_W), .RW(9), .DIVISOR(DAYS_PER_YEAR)) u_yoe (
      .clock (clock),
      .en_i  (en_i[11:10]),
      .x_i   (side_ff[9].yoe_num),
      .quo_o (yoe_q),
      .rem_o ()
   );

   uscd_cdiv #(.XW(MP_NUM_W), .QW(MP_W), .RW(MP_REM_W), .DIVISOR(MP_DIVISOR)) u_mp (
      .clock (clock),
      .en_i  (en_i[15:14]),
      .x_i   (side_ff[13].mp_num),
      .quo_o (mp_q),
      .rem_o (mp_r)
   );

   // (5*doy + 2) mod 153 = 5*(day - 1) + small rest, so day - 1 = rest / 5
   uscd_cdiv #(.XW(MP_REM_W), .QW(DOM_W), .RW(3), .DIVISOR(DOM_DIVISOR)) u_dom (
      .clock (clock),
      .en_i  (en_i[17:16]),
      .x_i   (mp_r),
      .quo_o (dom_q),
      .rem_o ()
   );

endmodule

/* sv/unix_seconds_to_civil_date.sv */
// Unix seconds to proleptic Gregorian date and time of day.
//
// req channel: one 64-bit unsigned count of seconds since 1970-01-01 00:00 UTC
// per transaction. rsp channel: year (low 16 bits), month 1-12, day 1-31,
// hour, minute, second and weekday (0 = Sunday), one result per request.
//
// The request is carried through 25 registered stages and rsp_valid is the
// valid bit of the last one. The 25 stages are set by the chain of constant
// dividers (seconds per day, days per era, then year, month and day), each
// split into a multiply stage and a correction stage. Throughput is one
// transaction per cycle while rsp_ready is high.
//
// Every stage has its own valid bit and may load whenever the stage after it
// loads or it is empty, so a stalled rsp side only holds the full stages; the
// pipeline keeps taking requests until all 25 stages hold an item. Nothing is
// dropped or repeated under stall. Reset clears the valid bits and leaves the
// pipeline empty; the data registers are not reset.
module unix_seconds_to_civil_date
   import uscd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SECS_W-1:0]   req_epoch_seconds,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [YEAR_W-1:0]   rsp_year,
   output logic [MONTH_W-1:0]  rsp_month,
   output logic [DOM_W-1:0]    rsp_day_of_month,
   output logic [HOUR_W-1:0]   rsp_hour,
   output logic [MINUTE_W-1:0] rsp_minute,
   output logic [SECOND_W-1:0] rsp_second,
   output logic [WDAY_W-1:0]   rsp_weekday
);

   logic [NUM_STAGES-1:0] valid_in, valid_ff;
   logic [NUM_STAGES-1:0] en;
   logic                  carry;
   logic [DAYS_W-1:0]     days;
   logic [TOD_W-1:0]      tod;
   result_type            rsp;

   // a stage loads when it is empty or the stage after it loads
   always_comb begin
      carry = rsp_ready;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         en[i] = carry || !valid_ff[i];
         carry = en[i];
      end
   end

   assign valid_in = {valid_ff[NUM_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (valid_in & en) | (valid_ff & ~en);
      end
   end

   uscd_days u_days (
      .clock  (clock),
      .en_i   (en[DAYS_STAGES-1:0]),
      .secs_i (req_epoch_seconds),
      .days_o (days),
      .tod_o  (tod)
   );

   uscd_civil u_civil (
      .clock  (clock),
      .en_i   (en[NUM_STAGES-1:DAYS_STAGES]),
      .days_i (days),
      .tod_i  (tod),
      .rsp_o  (rsp)
   );

   assign req_ready        = en[0];
   assign rsp_valid        = valid_ff[NUM_STAGES-1];
   assign rsp_year         = rsp.year;
   assign rsp_month        = rsp.month;
   assign rsp_day_of_month = rsp.day_of_month;
   assign rsp_hour         = rsp.hour;
   assign rsp_minute       = rsp.minute;
   assign rsp_second       = rsp.second;
   assign rsp_weekday      = rsp.weekday;

endmodule

/* tb/civil_date_checker.sv */
`timescale 1ns / 100ps

module civil_date_checker
   import uscd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [SECS_W-1:0]   req_epoch_seconds,

   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [YEAR_W-1:0]   rsp_year,
   input  logic [MONTH_W-1:0]  rsp_month,
   input  logic [DOM_W-1:0]    rsp_day_of_month,
   input  logic [HOUR_W-1:0]   rsp_hour,
   input  logic [MINUTE_W-1:0] rsp_minute,
   input  logic [SECOND_W-1:0] rsp_second,
   input  logic [WDAY_W-1:0]   rsp_weekday,

   output int                  fail_count,
   output int                  pending,
   output int                  checked_count
);

   localparam logic [63:0] SECS_PER_DAY = 64'd86400;
   localparam int REPORT_LIMIT = 10;

   result_type        expected_dates[$];
   logic [SECS_W-1:0] expected_seconds[$];
   int                errors = 0;
   int                checked = 0;

   // March-based era arithmetic, 400-year eras of 146097 days
   function automatic result_type civil_date_of(input logic [SECS_W-1:0] secs);
      logic [63:0] days, tod, z, era, doe, yoe, yr, doy, mp, dom, mon, wd;
      result_type  r;
      days = secs / SECS_PER_DAY;
      tod  = secs % SECS_PER_DAY;
      wd   = (days + 64'd4) % 64'(DAYS_PER_WEEK);
      z    = days + 64'(EPOCH_SHIFT);
      era  = z / 64'(DAYS_PER_ERA);
      doe  = z - era * 64'(DAYS_PER_ERA);
      yoe  = (doe - doe / 64'(DAYS_PER_4Y) + doe / 64'(DAYS_PER_CENTURY)
              - doe / 64'(DAYS_PER_ERA - 1)) / 64'(DAYS_PER_YEAR);
      yr   = yoe + era * 64'(YEARS_PER_ERA);
      doy  = doe - (64'(DAYS_PER_YEAR) * yoe + yoe / 64'd4 - yoe / 64'd100);
      mp   = (64'd5 * doy + 64'd2) / 64'(MP_DIVISOR);
      dom  = doy - (64'(MP_DIVISOR) * mp + 64'd2) / 64'(DOM_DIVISOR) + 64'd1;
      mon  = (mp < 64'(MP_JANUARY)) ? mp + 64'd3 : mp - 64'd9;
      // January and February belong to the next civil year
      if (mon <= 64'd2) begin
         yr = yr + 64'd1;
      end
      r.year         = yr[YEAR_W-1:0];
      r.month        = mon[MONTH_W-1:0];
      r.day_of_month = dom[DOM_W-1:0];
      r.hour         = 5'(tod / 64'(SECS_PER_HOUR));
      r.minute       = 6'((tod / 64'(SECS_PER_MIN)) % 64'(SECS_PER_MIN));
      r.second       = 6'(tod % 64'(SECS_PER_MIN));
      r.weekday      = wd[WDAY_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      result_type        want;
      result_type        got;
      logic [SECS_W-1:0] secs;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.year         = rsp_year;
            got.month        = rsp_month;
            got.day_of_month = rsp_day_of_month;
            got.hour         = rsp_hour;
            got.minute       = rsp_minute;
            got.second       = rsp_second;
            got.weekday      = rsp_weekday;
            if (expected_dates.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: unexpected result %0d-%0d-%0d %0d:%0d:%0d wd %0d", $realtime,
                           got.year, got.month, got.day_of_month, got.hour, got.minute,
                           got.second, got.weekday);
            end else begin
               want = expected_dates.pop_front();
               secs = expected_seconds.pop_front();
               checked++;
               if (got.year !== want.year || got.month !== want.month ||
                   got.day_of_month !== want.day_of_month || got.hour !== want.hour ||
                   got.minute !== want.minute || got.second !== want.second ||
                   got.weekday !== want.weekday) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display("%0t: seconds %0d expected %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                              $realtime, secs,
                              want.year, want.month, want.day_of_month, want.hour,
                              want.minute, want.second, want.weekday);
                     $display("%0t:    got %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                              $realtime,
                              got.year, got.month, got.day_of_month, got.hour,
                              got.minute, got.second, got.weekday);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_dates.push_back(civil_date_of(req_epoch_seconds));
            expected_seconds.push_back(req_epoch_seconds);
         end
      end
      fail_count    <= errors;
      pending       <= expected_dates.size();
      checked_count <= checked;
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import uscd_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 2 * NUM_STAGES + 20;
   localparam int MAX_GAP      = 8;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [SECS_W-1:0]   req_epoch_seconds = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [YEAR_W-1:0]   rsp_year;
   logic [MONTH_W-1:0]  rsp_month;
   logic [DOM_W-1:0]    rsp_day_of_month;
   logic [HOUR_W-1:0]   rsp_hour;
   logic [MINUTE_W-1:0] rsp_minute;
   logic [SECOND_W-1:0] rsp_second;
   logic [WDAY_W-1:0]   rsp_weekday;

   int fail_count;
   int pending;
   int checked_count;
   int cycles = 0;
   int sent = 0;
   int corner_count = 0;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;

   unix_seconds_to_civil_date dut (.*);

   civil_date_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
         $display("testbench NOT OK");
         $finish;
      end
   end

   // valid stays up across back-to-back transactions
   task automatic send_timestamp(input logic [SECS_W-1:0] secs);
      int gap;
      if ($urandom_range(0, 39) == 0)
         req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic send_corner(input logic [SECS_W-1:0] secs);
      corner_count++;
      send_timestamp(secs);
   endtask

   function automatic logic [SECS_W-1:0] random_seconds();
      logic [63:0] days;
      logic [63:0] v;
      case ($urandom_range(0, 4))
         0: v = {$urandom, $urandom};
         1: v = {$urandom, $urandom} >> $urandom_range(1, 63);
         2, 3: begin
            // dates up to about year 10000, often on a day boundary
            days = 64'($urandom_range(0, 3000000));
            case ($urandom_range(0, 2))
               0: v = days * 64'd86400;
               1: v = days * 64'd86400 + 64'd86399;
               default: v = days * 64'd86400 + 64'($urandom_range(0, 86399));
            endcase
         end
         default: v = ~64'd0 - 64'($urandom_range(0, 1000000));
      endcase
      return v;
   endfunction

   initial begin : responder
      int stall;
      forever begin
         if ($urandom_range(0, 39) == 0)
            rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_corner(64'd0);
      send_corner(64'd59);
      send_corner(64'd3599);
      send_corner(64'd86399);
      send_corner(64'd86400);
      send_corner(64'd946684799);              // end of 1999
      send_corner(64'd946684800);
      send_corner(64'd951782399);              // last second before a 400-year leap day
      send_corner(64'd951782400);
      send_corner(64'd951868800);              // start of an era (March 1st 2000)
      send_corner(64'd4107456000);             // 2100 is not a leap year
      send_corner(64'd4107542400);
      send_corner(64'd4294967295);
      send_corner(64'd253402300799);
      send_corner(64'h5555_5555_5555_5555);
      send_corner(64'hAAAA_AAAA_AAAA_AAAA);
      send_corner(64'h7FFF_FFFF_FFFF_FFFF);
      send_corner(64'h8000_0000_0000_0000);   // year wraps past 16 bits, as it already does for the three values above
      send_corner(64'hFFFF_FFFF_FFFF_FFFE);
      send_corner(64'hFFFF_FFFF_FFFF_FFFF);

      for (int i = 0; i < RANDOM_ITEMS; i++)
         send_timestamp(random_seconds());

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d timestamps converted: %0d calendar corners, rest random over 64 bits",
               sent, corner_count);
      $display("%0d dates compared, %0d mismatches", checked_count, fail_count);
      if (fail_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

/* files.f */
sv/uscd_pkg.sv
sv/uscd_cdiv.sv
sv/uscd_days.sv
sv/uscd_civil.sv
sv/unix_seconds_to_civil_date.sv
tb/civil_date_checker.sv
tb/testbench.sv
